@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared widths, codes and control types of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int ADDR_W     = $clog2(HEAP_UNITS);
  localparam int SIZE_W     = 13;
  localparam int WALK_LIMIT = HEAP_UNITS + 2;
  localparam int CNT_W      = $clog2(WALK_LIMIT);
  localparam int REQ_W      = 16;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_DONATE = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_NULL    = 3'd3,
    ST_ZERO    = 3'd4,
    ST_SMALL   = 3'd5
  } st_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_SETST,
    OP_RD_P,
    OP_RD_BP,
    OP_RD_NX,
    OP_A_FIRST,
    OP_A_STEP,
    OP_A_CUT2,
    OP_F_CHK,
    OP_D_WR,
    OP_I_STEP,
    OP_I_UP,
    OP_I_LO
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    st_e    st;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic req_zero;
    logic addr_zero;
    logic dsmall;
    logic hit;
    logic exact;
    logic a_stop;
    logic size_zero;
    logic found;
    logic last;
  } flags_t;

endpackage

@@ rtl/ffa_ram.sv @@
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/ffa_dp.sv @@
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: header memories, sentinel, rover and the walk registers.
// ----------------------------------------------------------------------------
module ffa_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                action_i,
  input  logic [ffa_pkg::REQ_W-1:0] request_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0] block_addr_i,
  input  logic [ffa_pkg::REQ_W-1:0] donate_bytes_i,
  input  ffa_pkg::cmd_t             cmd_i,
  output ffa_pkg::flags_t           flags_o,
  output logic [ffa_pkg::ADDR_W-1:0] result_addr_o,
  output logic [2:0]                status_o
);
  import ffa_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WALK_LIMIT - 1);

  act_e              act_q, act_d;
  logic              req_zero_q, req_zero_d, addr_zero_q, addr_zero_d;
  logic              dsmall_q, dsmall_d, rd_zero_q, rd_zero_d;
  logic [SIZE_W-1:0] nunits_q, nunits_d, bsz_q, bsz_d;
  logic [ADDR_W-1:0] dsz_q, dsz_d;
  logic [ADDR_W-1:0] bp_q, bp_d, p_q, p_d, prev_q, prev_d, nx_q, nx_d, pn_q, pn_d;
  logic [SIZE_W-1:0] psz_q, psz_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] rover_q, rover_d, sent_q, sent_d, res_q, res_d;
  st_e               st_q, st_d;

  logic              we_n, we_s;
  logic [ADDR_W-1:0] wa_n, wa_s, wd_n, raddr;
  logic [SIZE_W-1:0] wd_s;
  logic [ADDR_W-1:0] ram_next, rd_next;
  logic [SIZE_W-1:0] ram_size, rd_size;
  logic [SIZE_W-1:0] cut;
  logic [SIZE_W:0]   up_sum, lo_sum;
  logic              found;

  ffa_ram #(.WIDTH(ADDR_W), .DEPTH(HEAP_UNITS)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (we_n && (wa_n != '0)),
    .waddr_i(wa_n),
    .wdata_i(wd_n),
    .raddr_i(raddr),
    .rdata_o(ram_next)
  );

  ffa_ram #(.WIDTH(SIZE_W), .DEPTH(HEAP_UNITS)) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (we_s && (wa_s != '0)),
    .waddr_i(wa_s),
    .wdata_i(wd_s),
    .raddr_i(raddr),
    .rdata_o(ram_size)
  );

  // address zero is the sentinel: size reads zero, next lives in a register
  assign rd_next = rd_zero_q ? sent_q : ram_next;
  assign rd_size = rd_zero_q ? '0 : ram_size;

  assign cut    = rd_size - nunits_q;
  assign up_sum = {1'b0, bsz_q} + {1'b0, rd_size};
  assign lo_sum = {1'b0, psz_q} + {1'b0, bsz_q};
  assign found  = ((bp_q > p_q) && (bp_q < rd_next)) ||
                  ((p_q >= rd_next) && ((bp_q > p_q) || (bp_q < rd_next)));

  always_comb begin
    act_d       = act_q;
    req_zero_d  = req_zero_q;
    addr_zero_d = addr_zero_q;
    dsmall_d    = dsmall_q;
    rd_zero_d   = rd_zero_q;
    nunits_d    = nunits_q;
    bsz_d       = bsz_q;
    dsz_d       = dsz_q;
    bp_d        = bp_q;
    p_d         = p_q;
    prev_d      = prev_q;
    nx_d        = nx_q;
    pn_d        = pn_q;
    psz_d       = psz_q;
    cnt_d       = cnt_q;
    rover_d     = rover_q;
    res_d       = res_q;
    st_d        = st_q;
    we_n        = 1'b0;
    wa_n        = p_q;
    wd_n        = bp_q;
    we_s        = 1'b0;
    wa_s        = p_q;
    wd_s        = bsz_q;
    raddr       = p_q;
    case (cmd_i.op)
      OP_START: begin
        act_d       = act_e'(action_i);
        req_zero_d  = (request_bytes_i == '0);
        addr_zero_d = (block_addr_i == '0);
        dsmall_d    = (donate_bytes_i < REQ_W'(2 * UNIT_BYTES));
        nunits_d    = SIZE_W'(({1'b0, request_bytes_i} + (REQ_W+1)'(UNIT_BYTES - 1))
                              >> UNIT_SHIFT) + SIZE_W'(1);
        dsz_d       = ADDR_W'(donate_bytes_i >> UNIT_SHIFT);
        bp_d        = (action_i == ACT_FREE) ? block_addr_i - ADDR_W'(1) : block_addr_i;
        p_d         = rover_q;
        prev_d      = rover_q;
        cnt_d       = '0;
        res_d       = '0;
        st_d        = ST_OK;
      end
      OP_SETST: st_d = cmd_i.st;
      OP_RD_P: begin
        raddr     = p_q;
        rd_zero_d = (p_q == '0);
      end
      OP_RD_BP: begin
        raddr     = bp_q;
        rd_zero_d = (bp_q == '0);
      end
      OP_RD_NX: begin
        raddr     = nx_q;
        rd_zero_d = (nx_q == '0);
      end
      OP_A_FIRST: p_d = rd_next;
      OP_A_STEP: begin
        if (rd_size >= nunits_q) begin
          if (rd_size == nunits_q) begin
            we_n    = 1'b1;
            wa_n    = prev_q;
            wd_n    = rd_next;
            rover_d = prev_q;
            res_d   = p_q + ADDR_W'(1);
          end else begin
            // keep the head, hand out the tail
            we_s = 1'b1;
            wa_s = p_q;
            wd_s = cut;
            p_d  = p_q + cut[ADDR_W-1:0];
          end
        end else if ((p_q == rover_q) || (cnt_q == CNT_LAST)) begin
          st_d = ST_NOMEM;
        end else begin
          prev_d = p_q;
          p_d    = rd_next;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      OP_A_CUT2: begin
        we_s    = 1'b1;
        wa_s    = p_q;
        wd_s    = nunits_q;
        rover_d = prev_q;
        res_d   = p_q + ADDR_W'(1);
      end
      OP_F_CHK: begin
        bsz_d = rd_size;
        if (rd_size == '0) begin
          st_d = ST_ZERO;
        end
      end
      OP_D_WR: begin
        we_s  = 1'b1;
        wa_s  = bp_q;
        wd_s  = {1'b0, dsz_q};
        bsz_d = {1'b0, dsz_q};
      end
      OP_I_STEP: begin
        nx_d  = rd_next;
        psz_d = rd_size;
        if (!found) begin
          p_d   = rd_next;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_I_UP: begin
        we_n = 1'b1;
        wa_n = bp_q;
        if (({2'b0, bp_q} + {1'b0, bsz_q}) == {2'b0, nx_q} && !up_sum[SIZE_W]) begin
          we_s  = 1'b1;
          wa_s  = bp_q;
          wd_s  = up_sum[SIZE_W-1:0];
          bsz_d = up_sum[SIZE_W-1:0];
          wd_n  = rd_next;
          pn_d  = rd_next;
        end else begin
          wd_n = nx_q;
          pn_d = nx_q;
        end
      end
      OP_I_LO: begin
        we_n = 1'b1;
        wa_n = p_q;
        if (({2'b0, p_q} + {1'b0, psz_q}) == {2'b0, bp_q} && !lo_sum[SIZE_W]) begin
          we_s = 1'b1;
          wa_s = p_q;
          wd_s = lo_sum[SIZE_W-1:0];
          wd_n = pn_q;
        end else begin
          wd_n = bp_q;
        end
        rover_d = p_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sent_d = sent_q;
    if (we_n && (wa_n == '0)) begin
      sent_d = wd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= '0;
      sent_q  <= '0;
    end else begin
      rover_q <= rover_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    req_zero_q  <= req_zero_d;
    addr_zero_q <= addr_zero_d;
    dsmall_q    <= dsmall_d;
    rd_zero_q   <= rd_zero_d;
    nunits_q    <= nunits_d;
    bsz_q       <= bsz_d;
    dsz_q       <= dsz_d;
    bp_q        <= bp_d;
    p_q         <= p_d;
    prev_q      <= prev_d;
    nx_q        <= nx_d;
    pn_q        <= pn_d;
    psz_q       <= psz_d;
    cnt_q       <= cnt_d;
    res_q       <= res_d;
    st_q        <= st_d;
  end

  assign flags_o.act       = act_q;
  assign flags_o.req_zero  = req_zero_q;
  assign flags_o.addr_zero = addr_zero_q;
  assign flags_o.dsmall    = dsmall_q;
  assign flags_o.hit       = (rd_size >= nunits_q);
  assign flags_o.exact     = (rd_size == nunits_q);
  assign flags_o.a_stop    = (p_q == rover_q) || (cnt_q == CNT_LAST);
  assign flags_o.size_zero = (rd_size == '0);
  assign flags_o.found     = found;
  assign flags_o.last      = (cnt_q == CNT_LAST);

  assign result_addr_o = res_q;
  assign status_o      = st_q;

endmodule

@@ rtl/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: steps the datapath through allocate, free and donate.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  ffa_pkg::flags_t flags_i,
  output ffa_pkg::cmd_t   cmd_o
);
  import ffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_A_FIRST, S_A_RD, S_A_STEP, S_A_CUT2, S_F_CHK,
    S_I_RD, S_I_STEP, S_I_RDNX, S_I_UP, S_I_LO, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o.op = OP_NONE;
    cmd_o.st = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        case (flags_i.act)
          ACT_ALLOC: begin
            if (flags_i.req_zero) begin
              cmd_o.op = OP_SETST;
              cmd_o.st = ST_INVALID;
            end else begin
              cmd_o.op = OP_RD_P;
              state_d  = S_A_FIRST;
            end
          end
          ACT_FREE: begin
            if (flags_i.addr_zero) begin
              cmd_o.op = OP_SETST;
              cmd_o.st = ST_NULL;
            end else begin
              cmd_o.op = OP_RD_BP;
              state_d  = S_F_CHK;
            end
          end
          ACT_DONATE: begin
            if (flags_i.addr_zero) begin
              cmd_o.op = OP_SETST;
              cmd_o.st = ST_NULL;
            end else if (flags_i.dsmall) begin
              cmd_o.op = OP_SETST;
              cmd_o.st = ST_SMALL;
            end else begin
              cmd_o.op = OP_D_WR;
              state_d  = S_I_RD;
            end
          end
          default: ;
        endcase
      end
      S_A_FIRST: begin
        cmd_o.op = OP_A_FIRST;
        state_d  = S_A_RD;
      end
      S_A_RD: begin
        cmd_o.op = OP_RD_P;
        state_d  = S_A_STEP;
      end
      S_A_STEP: begin
        cmd_o.op = OP_A_STEP;
        if (flags_i.hit) begin
          state_d = flags_i.exact ? S_DONE : S_A_CUT2;
        end else begin
          state_d = flags_i.a_stop ? S_DONE : S_A_RD;
        end
      end
      S_A_CUT2: begin
        cmd_o.op = OP_A_CUT2;
        state_d  = S_DONE;
      end
      S_F_CHK: begin
        cmd_o.op = OP_F_CHK;
        state_d  = flags_i.size_zero ? S_DONE : S_I_RD;
      end
      S_I_RD: begin
        cmd_o.op = OP_RD_P;
        state_d  = S_I_STEP;
      end
      S_I_STEP: begin
        cmd_o.op = OP_I_STEP;
        if (flags_i.found) begin
          state_d = S_I_RDNX;
        end else begin
          // a corrupt list that never closes is dropped quietly
          state_d = flags_i.last ? S_DONE : S_I_RD;
        end
      end
      S_I_RDNX: begin
        cmd_o.op = OP_RD_NX;
        state_d  = S_I_UP;
      end
      S_I_UP: begin
        cmd_o.op = OP_I_UP;
        state_d  = S_I_LO;
      end
      S_I_LO: begin
        cmd_o.op = OP_I_LO;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result word shown while a new word could be taken");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("accepted word did not start a request");

  a_result_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result word repeated after it was taken");

endmodule

@@ rtl/first_fit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Free-list heap allocator over a unit arena with coalescing on free.
// ----------------------------------------------------------------------------
// An input word carries action_i (allocate, free, donate), request_bytes_i,
// block_addr_i and donate_bytes_i; it is taken when in_valid_i is high and
// in_stall_o is low. Exactly one result word (result_addr_o, status_o)
// comes back per request, held on the output while out_stall_i is high.
// One request is in work at a time: in_stall_o stays high from the accept
// until the result word is taken.
// Time is set by the free-list walk through the header memories: each
// header visited is a registered read, then a decide step. Allocate walks
// until a block fits and splits a larger block in a further step; free
// reads the block header first, then free and donate walk to the insert
// point and merge with adjacent neighbours; rejected requests go straight
// to the result. A walk visits at most HEAP_UNITS + 2 headers.
// After reset the list holds only the sentinel (pointing to itself) and the
// rover sits on it; headers are valid once written by donate or split.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [ffa_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0] block_addr_i,
  input  logic [ffa_pkg::REQ_W-1:0]  donate_bytes_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ffa_pkg::ADDR_W-1:0] result_addr_o,
  output logic [2:0]                 status_o
);
  import ffa_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  ffa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .request_bytes_i(request_bytes_i),
    .block_addr_i   (block_addr_i),
    .donate_bytes_i (donate_bytes_i),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .result_addr_o  (result_addr_o),
    .status_o       (status_o)
  );

endmodule
